@@ src/dlr_pkg.sv @@
// Shared types and constants for the dashed line rasterizer.
package dlr_pkg;

  localparam int COORD_W     = 7;
  localparam int COLOR_W     = 8;
  localparam int DASH_W      = 4;
  localparam int COORD_BITS  = 7;
  localparam int MAX_RESULTS = 64;
  localparam logic [DASH_W-1:0] DASH_RESET = 4'd2;

  // Status of the stepper towards the sequencer
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               on;
    logic               fin;
    logic               empty;
  } step_stat_t;

endpackage

@@ src/dlr_step.sv @@
// Bresenham stepper: line setup, error term, dash run counter.
module dlr_step #(
  parameter int CB = dlr_pkg::COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic                         adv,
  input  logic [CB-1:0]                sx,
  input  logic [CB-1:0]                sy,
  input  logic [CB-1:0]                ex,
  input  logic [CB-1:0]                ey,
  input  logic [dlr_pkg::DASH_W-1:0]   dash,
  output dlr_pkg::step_stat_t          stat
);

  localparam int ERR_W = CB + 2;

  logic [CB-1:0] ax, ay, bx, by, dx, dy, maj, mnr;
  logic [CB:0]   maj_p1;
  logic          ymaj, yneg;

  logic [CB-1:0]             px_r, py_r, maj_r, mnr_r, steps_r;
  logic signed [ERR_W-1:0]   err_r, err_sum, err_nxt;
  logic                      ymaj_r, yneg_r, on_r, on_nxt;
  logic [dlr_pkg::DASH_W-1:0] run_r, run_dec, run_nxt;
  logic [CB-1:0]             py_step, px_nxt, py_nxt;

  // setup: order ends so x rises, pick the major axis
  always_comb begin
    if (sx > ex) begin
      ax = ex; ay = ey; bx = sx; by = sy;
    end else begin
      ax = sx; ay = sy; bx = ex; by = ey;
    end
    dx     = bx - ax;
    yneg   = by < ay;
    dy     = yneg ? (ay - by) : (by - ay);
    ymaj   = dy > dx;
    maj    = ymaj ? dy : dx;
    mnr    = ymaj ? dx : dy;
    maj_p1 = (CB+1)'(maj) + (CB+1)'(1);
  end

  // one step of the walk
  always_comb begin
    py_step = yneg_r ? (py_r - CB'(1)) : (py_r + CB'(1));
    err_sum = err_r + $signed(ERR_W'(mnr_r));
    px_nxt  = px_r;
    py_nxt  = py_r;
    err_nxt = err_sum;
    if (ymaj_r) py_nxt = py_step;
    else        px_nxt = px_r + CB'(1);
    if (err_sum > $signed(ERR_W'(0))) begin
      err_nxt = err_sum - $signed(ERR_W'(maj_r));
      if (ymaj_r) px_nxt = px_r + CB'(1);
      else        py_nxt = py_step;
    end
    run_dec = run_r - dlr_pkg::DASH_W'(1);
    run_nxt = run_dec;
    on_nxt  = on_r;
    if (run_dec == '0) begin
      on_nxt  = ~on_r;
      run_nxt = dash;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
    end else if (load) begin
      px_r    <= ax;
      py_r    <= ay;
      maj_r   <= maj;
      mnr_r   <= mnr;
      ymaj_r  <= ymaj;
      yneg_r  <= yneg;
      steps_r <= maj;
      err_r   <= ERR_W'(0) - $signed(ERR_W'(maj_p1[CB:1]));
      run_r   <= dash;
      on_r    <= 1'b1;
    end else if (adv) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      err_r   <= err_nxt;
      steps_r <= steps_r - CB'(1);
      run_r   <= run_nxt;
      on_r    <= on_nxt;
    end
  end

  assign stat.x     = dlr_pkg::COORD_W'(px_r);
  assign stat.y     = dlr_pkg::COORD_W'(py_r);
  assign stat.on    = on_r;
  assign stat.fin   = steps_r == CB'(1);
  assign stat.empty = steps_r == '0;

endmodule

@@ src/dashed_line_rasterizer_core.sv @@
// Top level of the dashed line rasterizer: sequencer, pending pixel and output register.
//
// One line command is taken when the block is idle; it then walks the major
// axis one pixel per cycle through a single stepper while the output side
// does not stall, and the input stays stalled until the command is done.
// Each drawn pixel is held back one place so that the final one can carry
// last; at most 64 pixels are given per command. A zero-length line gives
// no item.
module dashed_line_rasterizer_core #(
  parameter int COORD_BITS = dlr_pkg::COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dlr_pkg::DASH_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dlr_pkg::COORD_W-1:0]   in_start_x,
  input  logic [dlr_pkg::COORD_W-1:0]   in_start_y,
  input  logic [dlr_pkg::COORD_W-1:0]   in_end_x,
  input  logic [dlr_pkg::COORD_W-1:0]   in_end_y,
  input  logic [dlr_pkg::COLOR_W-1:0]   in_color,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dlr_pkg::COORD_W-1:0]   out_pixel_x,
  output logic [dlr_pkg::COORD_W-1:0]   out_pixel_y,
  output logic [dlr_pkg::COLOR_W-1:0]   out_pixel_color,
  output logic                          out_last
);

  localparam int CNT_W = $clog2(dlr_pkg::MAX_RESULTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FLUSH} state_t;

  state_t                        state_r;
  logic [dlr_pkg::DASH_W-1:0]    dash_r;
  logic [dlr_pkg::COLOR_W-1:0]   color_r;
  logic [CNT_W-1:0]              count_r;
  logic                          pend_vld_r;
  logic [dlr_pkg::COORD_W-1:0]   pend_x_r, pend_y_r;
  logic                          out_valid_r, out_last_r;
  logic [dlr_pkg::COORD_W-1:0]   out_x_r, out_y_r;
  logic [dlr_pkg::COLOR_W-1:0]   out_color_r;

  dlr_pkg::step_stat_t st;
  logic in_acc, out_free, adv, emit, cap_hit, out_load;

  assign in_stall = state_r != S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign adv      = state_r == S_RUN && !st.empty && out_free;
  assign emit     = adv && st.on;
  assign cap_hit  = count_r == CNT_W'(dlr_pkg::MAX_RESULTS - 1);
  assign out_load = (emit && pend_vld_r) || (state_r == S_FLUSH && pend_vld_r && out_free);

  dlr_step #(
    .CB (COORD_BITS)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_acc),
    .adv   (adv),
    .sx    (in_start_x[COORD_BITS-1:0]),
    .sy    (in_start_y[COORD_BITS-1:0]),
    .ex    (in_end_x[COORD_BITS-1:0]),
    .ey    (in_end_y[COORD_BITS-1:0]),
    .dash  (dash_r),
    .stat  (st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dash_r <= dlr_pkg::DASH_RESET;
    end else if (cfg_we) begin
      dash_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            color_r    <= in_color;
            count_r    <= '0;
            pend_vld_r <= 1'b0;
            state_r    <= S_RUN;
          end
        end
        S_RUN: begin
          if (st.empty) begin
            state_r <= S_FLUSH;
          end else if (adv) begin
            if (emit) begin
              // release the held pixel, hold the new one
              if (pend_vld_r) begin
                out_x_r     <= pend_x_r;
                out_y_r     <= pend_y_r;
                out_color_r <= color_r;
                out_last_r  <= 1'b0;
              end
              pend_vld_r <= 1'b1;
              pend_x_r   <= st.x;
              pend_y_r   <= st.y;
              count_r    <= count_r + CNT_W'(1);
            end
            if (st.fin || (emit && cap_hit)) state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!pend_vld_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_x_r     <= pend_x_r;
            out_y_r     <= pend_y_r;
            out_color_r <= color_r;
            out_last_r  <= 1'b1;
            pend_vld_r  <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_color_r;
  assign out_last        = out_last_r;

endmodule
